@@ src/tsbe_pkg.sv @@
`timescale 1ns / 1ps

package tsbe_pkg;

  typedef enum logic [2:0] {
    OP_DRAW   = 3'd0,
    OP_CURSOR = 3'd1,
    OP_CLEAR  = 3'd2,
    OP_SCROLL = 3'd3,
    OP_SIZE   = 3'd4,
    OP_READ   = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    KIND_PORT = 2'd0,
    KIND_SIZE = 2'd1,
    KIND_CELL = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ADDR,
    S_DRAW,
    S_RDREQ,
    S_RDOUT,
    S_SIZE,
    S_CUR,
    S_FILL,
    S_SCROLL,
    S_SDRAIN
  } state_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] glyph;
    logic [3:0] fg_idx;
    logic [3:0] bg_idx;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic [9:0]  port_addr;
    logic [7:0]  port_data;
    logic [7:0]  width_out;
    logic [7:0]  height_out;
    logic [15:0] cell_word;
    logic        last;
  } out_t;

  localparam logic [15:0] BlankReset  = 16'h0f20;
  localparam logic [9:0]  CrtcIndex   = 10'h3d4;
  localparam logic [9:0]  CrtcData    = 10'h3d5;
  localparam logic [7:0]  CursorLoReg = 8'h0f;
  localparam logic [7:0]  CursorHiReg = 8'h0e;
  localparam logic        RegBlankIdx = 1'b0;

endpackage

@@ src/tsbe_cell_mem.sv @@
`timescale 1ns / 1ps

module tsbe_cell_mem #(
  parameter int Depth = 2000,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [Depth];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/tsbe_seq.sv @@
`timescale 1ns / 1ps

module tsbe_seq #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [15:0]    blank_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tsbe_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tsbe_pkg::out_t out_data_o
);
  import tsbe_pkg::*;

  localparam int Cells = COLS * ROWS;
  localparam int AW    = $clog2(Cells);
  localparam logic [AW-1:0] LastCell   = AW'(Cells - 1);
  localparam logic [AW-1:0] ScrollLast = AW'(Cells - COLS - 1);
  localparam logic [AW-1:0] ScrollBase = AW'(Cells - COLS);
  localparam logic [AW-1:0] ColsA      = AW'(COLS);

  state_e        state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [1:0]    step_q, step_d;
  logic          wpend_q, wpend_d;
  logic [AW-1:0] wpaddr_q, wpaddr_d;
  in_t           item_q, item_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          inside_q, inside_d;
  logic [15:0]   pos_q, pos_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0]   mem_wdata, mem_rdata;
  logic          out_free, emit;
  out_t          res;
  logic [15:0]   lin;

  tsbe_cell_mem #(
    .Depth(Cells),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign lin      = 16'(item_q.row) * 16'(COLS) + 16'(item_q.col);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    step_d    = step_q;
    wpend_d   = 1'b0;
    wpaddr_d  = wpaddr_q;
    item_d    = item_q;
    addr_d    = addr_q;
    inside_d  = inside_q;
    pos_d     = pos_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = blank_i;
    mem_re    = 1'b0;
    mem_raddr = addr_q;
    emit      = 1'b0;
    res       = '0;
    res.kind  = KIND_PORT;

    if (wpend_q) begin
      mem_we    = 1'b1;
      mem_waddr = wpaddr_q;
      mem_wdata = mem_rdata;
    end

    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = BlankReset;
        if (cnt_q == LastCell) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        pos_d    = lin;
        addr_d   = lin[AW-1:0];
        inside_d = ({1'b0, item_q.row} < 9'(ROWS)) && ({1'b0, item_q.col} < 9'(COLS));
        cnt_d    = '0;
        step_d   = '0;
        case (op_e'(item_q.opcode))
          OP_DRAW:   state_d = S_DRAW;
          OP_CURSOR: state_d = S_CUR;
          OP_CLEAR:  state_d = S_FILL;
          OP_SCROLL: state_d = S_SCROLL;
          OP_SIZE:   state_d = S_SIZE;
          OP_READ:   state_d = S_RDREQ;
          default:   state_d = S_IDLE;
        endcase
      end
      S_DRAW: begin
        mem_we    = inside_q;
        mem_waddr = addr_q;
        mem_wdata = {item_q.bg_idx, item_q.fg_idx, item_q.glyph};
        state_d   = S_IDLE;
      end
      S_RDREQ: begin
        mem_re  = 1'b1;
        state_d = S_RDOUT;
      end
      S_RDOUT: begin
        res.kind      = KIND_CELL;
        res.cell_word = inside_q ? mem_rdata : 16'h0000;
        res.last      = 1'b1;
        emit          = out_free;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SIZE: begin
        res.kind       = KIND_SIZE;
        res.width_out  = 8'(COLS);
        res.height_out = 8'(ROWS);
        res.last       = 1'b1;
        emit           = out_free;
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_CUR: begin
        res.kind = KIND_PORT;
        case (step_q)
          2'd0: begin
            res.port_addr = CrtcIndex;
            res.port_data = CursorLoReg;
          end
          2'd1: begin
            res.port_addr = CrtcData;
            res.port_data = pos_q[7:0];
          end
          2'd2: begin
            res.port_addr = CrtcIndex;
            res.port_data = CursorHiReg;
          end
          default: begin
            res.port_addr = CrtcData;
            res.port_data = pos_q[15:8];
            res.last      = 1'b1;
          end
        endcase
        emit = out_free;
        if (out_free) begin
          step_d = step_q + 1'b1;
          if (step_q == 2'd3) begin
            state_d = S_IDLE;
          end
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = blank_i;
        if (cnt_q == LastCell) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SCROLL: begin
        // read one row below, write back on the next cycle
        mem_re    = 1'b1;
        mem_raddr = cnt_q + ColsA;
        wpend_d   = 1'b1;
        wpaddr_d  = cnt_q;
        if (cnt_q == ScrollLast) begin
          state_d = S_SDRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SDRAIN: begin
        cnt_d   = ScrollBase;
        state_d = S_FILL;
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = emit ? 1'b1 : (out_valid_q && out_stall_i);
    out_d       = emit ? res : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      step_q      <= '0;
      wpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      wpend_q     <= wpend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wpaddr_q <= wpaddr_d;
    item_q   <= item_d;
    addr_q   <= addr_d;
    inside_q <= inside_d;
    pos_q    <= pos_d;
    out_q    <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ src/text_screen_buffer_engine.sv @@
// Text screen buffer: COLS x ROWS cells of 16 bits in one synchronous RAM.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one command per
// transfer; output channel (out_valid_o / out_stall_i / out_data_o) carries
// the results, one per transfer, with last set on the final one.
// The APB port holds blank_cell at byte address 0; pready is always high.
// After reset the block stalls its input while a clearing pass writes the
// reset value of the blank cell (BlankReset) to every entry.
// Commands run one at a time; each decodes its address first, then: draw
// writes one cell, get size and read cell give one result, cursor gives four
// results, clear blanks every cell, scroll copies each row up and blanks the last.
// The command timing comes from the single write port of the cell RAM, which
// clear and scroll sweep one entry per cycle, and its registered read.
// Results sit in one output register; a stalled receiver holds it, and the
// sequencer waits for it to drain before producing the next result, while
// the input side is already free to take a new command once the result is
// registered.
`timescale 1ns / 1ps

module text_screen_buffer_engine #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tsbe_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tsbe_pkg::out_t out_data_o,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);
  import tsbe_pkg::*;

  logic [15:0] blank_q, blank_d;

  assign pready  = 1'b1;
  assign blank_d = (psel && penable && pwrite && pready && paddr[2] == RegBlankIdx)
                 ? pwdata[15:0] : blank_q;
  assign prdata  = (paddr[2] == RegBlankIdx) ? {16'h0000, blank_q} : 32'h0000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= BlankReset;
    end else begin
      blank_q <= blank_d;
    end
  end

  tsbe_seq #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .blank_i    (blank_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command taken while another is in flight");

  a_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_SIZE |->
      out_data_o.width_out == 8'(COLS) && out_data_o.height_out == 8'(ROWS) &&
      out_data_o.last)
    else $error("bad size reply");

  a_port_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != KIND_PORT |->
      out_data_o.port_addr == 10'd0 && out_data_o.port_data == 8'd0)
    else $error("port fields set on non-port result");

  a_port_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KIND_PORT |->
      (out_data_o.port_addr == CrtcIndex || out_data_o.port_addr == CrtcData))
    else $error("cursor write to unexpected port");

endmodule
